// ===== rtl/core/bsps_pkg.sv =====
// ----------------------------------------------------------------------------
// Byte string presence search - shared definitions
// Opcodes and the flag bundle passed from the update stage to the compare
// stage.
// ----------------------------------------------------------------------------
package bsps_pkg;

	localparam logic OP_PATTERN = 1'b0;
	localparam logic OP_REGION  = 1'b1;

	typedef struct packed {
		logic region;   // region byte
		logic clr;      // pattern byte that starts a new pattern
		logic en;       // window holds enough bytes, compare counts
		logic last;     // final region byte, emit result
		logic err;      // overflow or pattern longer than region
		logic ok;       // pattern non-empty and no error
	} flags_t;

endpackage
// ----------------------------------------------------------------------------

// ===== rtl/core/bsps_state.sv =====
// ----------------------------------------------------------------------------
// Byte string presence search - request register and search state
// Registers each request, then updates pattern, window and counters and
// hands the per-byte flags to the compare stage.
// ----------------------------------------------------------------------------
module bsps_state #(
	parameter int MAX_PATTERN_BYTES = 32,
	localparam int CW = $clog2(MAX_PATTERN_BYTES + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic                                opcode,
	input  logic [7:0]                          data_byte,
	input  logic                                last_byte,
	input  logic                                s2_ready,
	output logic                                s2_load,
	output bsps_pkg::flags_t                    flags,
	output logic [MAX_PATTERN_BYTES-1:0][7:0]   window,
	output logic [MAX_PATTERN_BYTES-1:0][7:0]   pattern,
	output logic [CW-1:0]                       count
);
	import bsps_pkg::*;

	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PATTERN_BYTES);

	logic                               valid_s1;
	logic                               op_s1;
	logic [7:0]                         byte_s1;
	logic                               last_s1;
	logic                               accept;
	logic                               s1_move;
	logic [CW-1:0]                      count_q;
	logic                               ovf_q;
	logic [CW-1:0]                      seen_q;
	logic                               inreg_q;
	logic [CW-1:0]                      seen_next;
	logic                               pat_shift;
	logic [MAX_PATTERN_BYTES-1:0][7:0]  window_q;
	logic [MAX_PATTERN_BYTES-1:0][7:0]  pattern_q;

	assign req_stall = valid_s1 && !s2_ready;
	assign accept    = req_valid && !req_stall;
	assign s1_move   = valid_s1 && s2_ready;
	assign s2_load   = s1_move;

	assign seen_next = (seen_q < CNT_MAX) ? seen_q + CW'(1) : seen_q;
	assign pat_shift = (op_s1 == OP_PATTERN) && (inreg_q || (count_q < CNT_MAX));

	always_comb begin
		flags        = '0;
		flags.region = (op_s1 == OP_REGION);
		flags.clr    = (op_s1 == OP_PATTERN) && inreg_q;
		if (op_s1 == OP_REGION) begin
			flags.en   = (count_q != '0) && !ovf_q && (seen_next >= count_q);
			flags.last = last_s1;
			flags.err  = ovf_q || ((count_q != '0) && (seen_next < count_q));
			flags.ok   = (count_q != '0) && !flags.err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= opcode;
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			seen_q  <= '0;
			inreg_q <= 1'b0;
		end else if (s1_move) begin
			if (op_s1 == OP_PATTERN) begin
				if (inreg_q) begin
					count_q <= CW'(1);
					ovf_q   <= 1'b0;
					seen_q  <= '0;
					inreg_q <= 1'b0;
				end else if (count_q < CNT_MAX) begin
					count_q <= count_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end else begin
				inreg_q <= 1'b1;
				seen_q  <= last_s1 ? '0 : seen_next;
			end
		end
	end

	// window and pattern are shift lines, newest byte at lane 0
	always_ff @(posedge clk) begin
		if (s1_move && (op_s1 == OP_REGION)) begin
			window_q <= {window_q[MAX_PATTERN_BYTES-2:0], byte_s1};
		end
		if (s1_move && pat_shift) begin
			pattern_q <= {pattern_q[MAX_PATTERN_BYTES-2:0], byte_s1};
		end
	end

	assign window  = window_q;
	assign pattern = pattern_q;
	assign count   = count_q;

`ifndef SYNTH
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("pattern count beyond capacity");
	a_seen_range: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= CNT_MAX)
		else $error("byte count beyond capacity");
	a_new_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_move && (op_s1 == OP_PATTERN) && inreg_q) |=>
		(count_q == CW'(1)) && !ovf_q && (seen_q == '0))
		else $error("new pattern did not restart state");
`endif

endmodule
// ----------------------------------------------------------------------------

// ===== rtl/core/bsps_match.sv =====
// ----------------------------------------------------------------------------
// Byte string presence search - window compare and result register
// Compares every window lane with its pattern lane, keeps the sticky match
// flag and registers the result.
// ----------------------------------------------------------------------------
module bsps_match #(
	parameter int MAX_PATTERN_BYTES = 32,
	localparam int CW = $clog2(MAX_PATTERN_BYTES + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s2_load,
	input  bsps_pkg::flags_t                    flags,
	input  logic [MAX_PATTERN_BYTES-1:0][7:0]   window,
	input  logic [MAX_PATTERN_BYTES-1:0][7:0]   pattern,
	input  logic [CW-1:0]                       count,
	output logic                                s2_ready,
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic                                found,
	output logic                                pattern_error
);
	import bsps_pkg::*;

	logic                           valid_s2;
	flags_t                         flags_s2;
	logic [MAX_PATTERN_BYTES-1:0]   lane_ok;
	logic                           hit;
	logic                           match_q;
	logic                           match_now;
	logic                           out_ready;
	logic                           s2_move;
	logic                           res_valid_q;
	logic                           found_q;
	logic                           err_q;

	always_comb begin
		for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
			lane_ok[j] = (CW'(j) >= count) || (window[j] == pattern[j]);
		end
	end

	assign hit       = &lane_ok;
	assign match_now = match_q || (flags_s2.en && hit);
	assign out_ready = !res_valid_q || !res_stall;
	assign s2_move   = valid_s2 && (!flags_s2.last || out_ready);
	assign s2_ready  = !valid_s2 || s2_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_load) begin
			valid_s2 <= 1'b1;
		end else if (s2_move) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load) begin
			flags_s2 <= flags;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (s2_move) begin
				if (flags_s2.clr || flags_s2.last) begin
					match_q <= 1'b0;
				end else if (flags_s2.region) begin
					match_q <= match_now;
				end
			end
			if (s2_move && flags_s2.last) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move && flags_s2.last) begin
			found_q <= match_now && flags_s2.ok;
			err_q   <= flags_s2.err;
		end
	end

	assign res_valid     = res_valid_q;
	assign found         = found_q;
	assign pattern_error = err_q;

`ifndef SYNTH
	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_move && flags_s2.last) |=> res_valid_q)
		else $error("result not loaded on last byte");
	a_found_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(found_q && err_q))
		else $error("found reported together with error");
	a_match_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_move && flags_s2.last) |=> !match_q)
		else $error("match flag not cleared at region end");
`endif

endmodule
// ----------------------------------------------------------------------------

// ===== rtl/core/byte_string_presence_search_top.sv =====
// ----------------------------------------------------------------------------
// Byte string presence search - top level
// Streams pattern and region bytes and reports whether the pattern occurs
// anywhere in each region.
// ----------------------------------------------------------------------------
// One request per cycle is taken, pattern or region byte alike, while
// req_stall is low; a final region byte held back by res_stall stalls the
// requests. A request goes through an input register, a stage that updates
// the pattern and window shift lines, and a stage that compares all
// MAX_PATTERN_BYTES window lanes with the pattern in parallel; the result of
// a final region byte is then loaded into the result register. The parallel
// lane compare sets the rate of one byte per cycle when nothing stalls. An
// empty pattern reports not found without error; a pattern longer than
// MAX_PATTERN_BYTES or longer than the region reports not found with pattern_error set. Reset needs no clearing pass.
// ----------------------------------------------------------------------------
module byte_string_presence_search_top #(
	parameter int MAX_PATTERN_BYTES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        opcode,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        found,
	output logic        pattern_error
);
	import bsps_pkg::*;

	localparam int CW = $clog2(MAX_PATTERN_BYTES + 1);

	logic                               s2_ready;
	logic                               s2_load;
	flags_t                             flags;
	logic [MAX_PATTERN_BYTES-1:0][7:0]  window;
	logic [MAX_PATTERN_BYTES-1:0][7:0]  pattern;
	logic [CW-1:0]                      count;

	bsps_state #(
		.MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
	) u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.opcode    (opcode),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.s2_ready  (s2_ready),
		.s2_load   (s2_load),
		.flags     (flags),
		.window    (window),
		.pattern   (pattern),
		.count     (count)
	);

	bsps_match #(
		.MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
	) u_match (
		.clk           (clk),
		.arst_n        (arst_n),
		.s2_load       (s2_load),
		.flags         (flags),
		.window        (window),
		.pattern       (pattern),
		.count         (count),
		.s2_ready      (s2_ready),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.found         (found),
		.pattern_error (pattern_error)
	);

endmodule
// ----------------------------------------------------------------------------

// ===== verif/tb_byte_string_presence_search_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Byte string presence search - testbench
// Loads byte patterns and streams regions through the block. Each accepted
// request goes through a local search model; the found and error flags of
// every region end are checked in order. Both handshakes idle and stall at
// random, and a watchdog ends a hung run.
// ----------------------------------------------------------------------------
module tb_byte_string_presence_search_top;
	import bsps_pkg::*;

	localparam int PAT_MAX         = 32;
	localparam int RANDOM_REQUESTS = 950;
	localparam int IDLE_LIMIT      = 1000;
	localparam int DRAIN_CYCLES    = 8;

	typedef struct packed {
		logic       op;
		logic [7:0] data;
		logic       last;
	} request_t;

	typedef struct packed {
		logic found;
		logic err;
	} verdict_t;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       req_valid   = 1'b0;
	logic       req_stall;
	logic       opcode      = OP_PATTERN;
	logic [7:0] data_byte   = 8'h00;
	logic       last_byte   = 1'b0;
	logic       res_valid;
	logic       res_stall   = 1'b0;
	logic       found;
	logic       pattern_error;

	request_t request_queue [$];
	verdict_t expected_verdicts [$];
	request_t in_flight;
	bit       holding;
	int       send_gap    = 0;
	int       send_quiet  = 0;
	int       recv_hold   = 0;
	int       recv_quiet  = 0;
	int       idle_cycles = 0;
	int       mismatches  = 0;
	bit       took;

	// search model state
	logic [7:0] pat_bytes [PAT_MAX];
	int         pat_len     = 0;
	bit         pat_over    = 1'b0;
	logic [7:0] window [PAT_MAX];
	int         window_fill = 0;
	bit         hit         = 1'b0;
	bit         region_open = 1'b0;

	byte_string_presence_search_top #(
		.MAX_PATTERN_BYTES(PAT_MAX)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.opcode       (opcode),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.found        (found),
		.pattern_error(pattern_error)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void clear_window();
		foreach (window[i]) window[i] = 8'h00;
		window_fill = 0;
		hit = 1'b0;
	endfunction

	function automatic void search_step(request_t r);
		int       i;
		bit       same;
		bit       too_long;
		verdict_t v;
		if (r.op == OP_PATTERN) begin
			if (region_open) begin
				pat_len = 0;
				pat_over = 1'b0;
				region_open = 1'b0;
				clear_window();
			end
			if (pat_len < PAT_MAX) begin
				pat_bytes[pat_len] = r.data;
				pat_len++;
			end else begin
				pat_over = 1'b1;
			end
			return;
		end
		region_open = 1'b1;
		for (i = PAT_MAX - 1; i > 0; i--) window[i] = window[i - 1];
		window[0] = r.data;
		if (window_fill < PAT_MAX) window_fill++;
		if (pat_len > 0 && !pat_over && window_fill >= pat_len) begin
			same = 1'b1;
			for (i = 0; i < pat_len; i++)
				if (window[pat_len - 1 - i] != pat_bytes[i]) same = 1'b0;
			if (same) hit = 1'b1;
		end
		if (!r.last) return;
		too_long = pat_len > 0 && window_fill < pat_len;
		v.err = pat_over || too_long;
		v.found = hit && pat_len > 0 && !v.err;
		expected_verdicts = {expected_verdicts, v};
		clear_window();
	endfunction

	// random wait, with occasional runs of back-to-back traffic
	function automatic int draw_wait(inout int quiet);
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			quiet = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 15);
	endfunction

	task automatic queue_request(logic op, logic [7:0] data, logic last);
		request_t r;
		r.op = op;
		r.data = data;
		r.last = last;
		request_queue = {request_queue, r};
	endtask

	function automatic logic [7:0] pick_byte(bit narrow);
		return narrow ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
	endfunction

	// one pattern followed by a few regions, mostly ending properly
	task automatic queue_search_set();
		logic [7:0] pat [$];
		logic [7:0] span [$];
		int         len;
		int         stored;
		int         span_len;
		int         at;
		int         regions;
		int         roll;
		int         i;
		bit         narrow;
		roll = $urandom_range(0, 99);
		if (roll < 75) len = $urandom_range(1, 6);
		else if (roll < 87) len = $urandom_range(7, PAT_MAX - 1);
		else if (roll < 94) len = PAT_MAX;
		else len = $urandom_range(PAT_MAX + 1, PAT_MAX + 4);
		narrow = $urandom_range(0, 1);
		for (i = 0; i < len; i++) begin
			pat = {pat, pick_byte(narrow)};
			queue_request(OP_PATTERN, pat[i], 1'($urandom_range(0, 1)));
		end
		stored = (len < PAT_MAX) ? len : PAT_MAX;
		regions = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4);
		repeat (regions) begin
			roll = $urandom_range(0, 19);
			if (roll == 0 && stored > 1) span_len = $urandom_range(1, stored - 1);
			else if (roll == 1) span_len = stored + $urandom_range(20, 40);
			else span_len = stored + $urandom_range(0, 8);
			span.delete();
			for (i = 0; i < span_len; i++) span = {span, pick_byte(narrow)};
			if (span_len >= stored && $urandom_range(0, 1)) begin
				at = $urandom_range(0, span_len - stored);
				for (i = 0; i < stored; i++) span[at + i] = pat[i];
			end
			for (i = 0; i < span_len; i++)
				queue_request(OP_REGION, span[i],
					(i == span_len - 1) && ($urandom_range(0, 9) != 0));
		end
	endtask

	task automatic flag_error(string msg);
		mismatches++;
		if (mismatches <= 10) $display("ERROR @%0t: %s", $realtime, msg);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			send_gap = 0;
		end else begin
			holding = req_valid;
			if (req_valid && !req_stall) begin
				search_step(in_flight);
				holding = 1'b0;
				send_gap = draw_wait(send_quiet);
			end
			if (!holding) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (request_queue.size() > 0) begin
					in_flight = request_queue.pop_front();
					opcode <= in_flight.op;
					data_byte <= in_flight.data;
					last_byte <= in_flight.last;
					holding = 1'b1;
				end
			end
			req_valid <= holding;
		end
	end

	// result monitor and watchdog
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			recv_hold = 0;
			idle_cycles = 0;
		end else begin
			took = req_valid && !req_stall;
			if (res_valid && !res_stall) begin
				took = 1'b1;
				if (expected_verdicts.size() == 0) begin
					flag_error($sformatf("unexpected result found=%b pattern_error=%b",
						found, pattern_error));
				end else begin
					verdict_t v;
					v = expected_verdicts.pop_front();
					if (found !== v.found || pattern_error !== v.err)
						flag_error($sformatf("found exp %b got %b, pattern_error exp %b got %b",
							v.found, found, v.err, pattern_error));
				end
				recv_hold = draw_wait(recv_quiet);
			end
			res_stall <= (recv_hold > 0);
			if (recv_hold > 0) recv_hold--;
			idle_cycles = took ? 0 : idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL byte_string_presence_search_top");
				$finish;
			end
		end
	end

	initial begin
		// empty pattern right after reset
		queue_request(OP_REGION, 8'h00, 1'b1);
		queue_request(OP_REGION, 8'hFF, 1'b0);
		queue_request(OP_REGION, 8'h80, 1'b1);
		// two-byte pattern; last_byte on a pattern byte is ignored
		queue_request(OP_PATTERN, 8'h00, 1'b1);
		queue_request(OP_PATTERN, 8'hFF, 1'b0);
		queue_request(OP_REGION, 8'h00, 1'b0);
		queue_request(OP_REGION, 8'hFF, 1'b1);
		// region shorter than pattern
		queue_request(OP_REGION, 8'hFF, 1'b1);
		// match in the middle, then reversed order
		queue_request(OP_REGION, 8'h12, 1'b0);
		queue_request(OP_REGION, 8'h00, 1'b0);
		queue_request(OP_REGION, 8'hFF, 1'b0);
		queue_request(OP_REGION, 8'h34, 1'b1);
		queue_request(OP_REGION, 8'hFF, 1'b0);
		queue_request(OP_REGION, 8'h00, 1'b1);
		// new single-byte pattern after region data
		queue_request(OP_PATTERN, 8'h5A, 1'b0);
		queue_request(OP_REGION, 8'h5A, 1'b1);
		queue_request(OP_REGION, 8'hA5, 1'b1);

		while (request_queue.size() < 17 + RANDOM_REQUESTS) queue_search_set();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (request_queue.size() > 0 || req_valid || expected_verdicts.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_verdicts.size() == 0) begin
			$display("PASS byte_string_presence_search_top");
		end else begin
			$display("FAIL byte_string_presence_search_top");
		end
		$finish;
	end

endmodule
